>>> hw/rtl/hsl_to_rgb_converter_unit_defines.svh
// assertion macros for the hsl to rgb converter checker
// no dependencies; included by the checker file only
`ifndef HSL_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_UNIT_DEFINES_SVH

// condition must hold at every clock edge outside reset
`define HSL2RGB_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("hsl2rgb check failed");

// antecedent implies consequent in the same cycle
`define HSL2RGB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsl2rgb check failed");

// antecedent implies consequent a fixed number of cycles later
`define HSL2RGB_ASSERT_DELAY(label, ante, lat, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(lat) (cons)) \
        else $error("hsl2rgb check failed");

`endif

>>> hw/rtl/hsl2rgb_pkg.sv
// shared constants and types for the hsl to rgb converter
// no dependencies; used by every module of the block
package hsl2rgb_pkg;

    localparam int unsigned SAT_MAX    = 65535;
    localparam int unsigned CHAN_MAX   = 255;
    localparam int unsigned PIPE_DEPTH = 5;

    typedef enum logic [2:0] {
        SECTOR_RED_YEL  = 3'd0,
        SECTOR_YEL_GRN  = 3'd1,
        SECTOR_GRN_CYN  = 3'd2,
        SECTOR_CYN_BLU  = 3'd3,
        SECTOR_BLU_MAG  = 3'd4,
        SECTOR_MAG_RED  = 3'd5
    } sector_t;

endpackage

>>> hw/rtl/hsl2rgb_norm.sv
// normalisation stages: saturation and lightness to fixed point, chroma factor from lightness, hue to sector and ramp
// depends on hsl2rgb_pkg
module hsl2rgb_norm #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [15:0]              hue,
    input  logic [15:0]              saturation,
    input  logic [15:0]              lightness,
    output logic                     out_valid,
    output logic [FRAC_BITS:0]       s_frac,
    output logic [FRAC_BITS:0]       l_frac,
    output logic [FRAC_BITS:0]       k_frac,
    output logic [FRAC_BITS:0]       w_frac,
    output hsl2rgb_pkg::sector_t     sector
);

    localparam int NW = 16 + FRAC_BITS;
    localparam logic [FRAC_BITS+1:0] ONE = (FRAC_BITS+2)'(1) << FRAC_BITS;

    // stage 1: quotient estimates and hue position
    logic [NW-1:0]        s_num;
    logic [NW-1:0]        l_num;
    logic [NW:0]          s_sum;
    logic [NW:0]          l_sum;
    logic [FRAC_BITS:0]   s_est_next;
    logic [FRAC_BITS:0]   l_est_next;
    logic [18:0]          hue6;
    logic [18+FRAC_BITS:0] hue_wide;
    logic [FRAC_BITS+2:0] hp_next;

    logic                 v1_reg;
    logic [15:0]          sat_reg;
    logic [15:0]          lit_reg;
    logic [FRAC_BITS:0]   s_est_reg;
    logic [FRAC_BITS:0]   l_est_reg;
    logic [FRAC_BITS+2:0] hp_reg;

    always_comb
    begin
        s_num      = {saturation, {FRAC_BITS{1'b0}}};
        l_num      = {lightness, {FRAC_BITS{1'b0}}};
        s_sum      = {1'b0, s_num} + {17'd0, s_num[NW-1:16]};
        l_sum      = {1'b0, l_num} + {17'd0, l_num[NW-1:16]};
        s_est_next = s_sum[NW:16];
        l_est_next = l_sum[NW:16];
        hue6       = ({3'd0, hue} << 2) + ({3'd0, hue} << 1);
        hue_wide   = {hue6, {FRAC_BITS{1'b0}}};
        hp_next    = hue_wide[18+FRAC_BITS:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg   <= saturation;
        lit_reg   <= lightness;
        s_est_reg <= s_est_next;
        l_est_reg <= l_est_next;
        hp_reg    <= hp_next;
    end

    // stage 2: quotient correction, chroma factor, ramp weight
    logic [NW:0]          s_back;
    logic [NW:0]          l_back;
    logic [NW:0]          s_rem;
    logic [NW:0]          l_rem;
    logic [FRAC_BITS:0]   s_next;
    logic [FRAC_BITS:0]   l_next;
    logic [FRAC_BITS+1:0] two_l;
    logic [FRAC_BITS+1:0] dev;
    logic [FRAC_BITS+1:0] k_wide;
    logic [FRAC_BITS:0]   t_pos;
    logic [FRAC_BITS+1:0] td;
    logic [FRAC_BITS+1:0] w_wide;

    logic                 v2_reg;
    logic [FRAC_BITS:0]   s_reg;
    logic [FRAC_BITS:0]   l_reg;
    logic [FRAC_BITS:0]   k_reg;
    logic [FRAC_BITS:0]   w_reg;
    hsl2rgb_pkg::sector_t sector_reg;

    always_comb
    begin
        s_back = {s_est_reg, 16'd0} - {16'd0, s_est_reg};
        l_back = {l_est_reg, 16'd0} - {16'd0, l_est_reg};
        s_rem  = {1'b0, sat_reg, {FRAC_BITS{1'b0}}} - s_back;
        l_rem  = {1'b0, lit_reg, {FRAC_BITS{1'b0}}} - l_back;
        s_next = s_est_reg + (FRAC_BITS+1)'(s_rem >= (NW+1)'(hsl2rgb_pkg::SAT_MAX));
        l_next = l_est_reg + (FRAC_BITS+1)'(l_rem >= (NW+1)'(hsl2rgb_pkg::SAT_MAX));
        two_l  = {l_next, 1'b0};
        dev    = (two_l >= ONE) ? (two_l - ONE) : (ONE - two_l);
        k_wide = ONE - dev;
        t_pos  = hp_reg[FRAC_BITS:0];
        td     = ({1'b0, t_pos} >= ONE) ? ({1'b0, t_pos} - ONE) : (ONE - {1'b0, t_pos});
        w_wide = ONE - td;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg      <= s_next;
        l_reg      <= l_next;
        k_reg      <= k_wide[FRAC_BITS:0];
        w_reg      <= w_wide[FRAC_BITS:0];
        sector_reg <= hsl2rgb_pkg::sector_t'(hp_reg[FRAC_BITS+2:FRAC_BITS]);
    end

    assign out_valid = v2_reg;
    assign s_frac    = s_reg;
    assign l_frac    = l_reg;
    assign k_frac    = k_reg;
    assign w_frac    = w_reg;
    assign sector    = sector_reg;

endmodule

>>> hw/rtl/hsl2rgb_chroma.sv
// multiply stages: chroma, secondary component and lightness offset
// depends on hsl2rgb_pkg
module hsl2rgb_chroma #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [FRAC_BITS:0]       s_frac,
    input  logic [FRAC_BITS:0]       l_frac,
    input  logic [FRAC_BITS:0]       k_frac,
    input  logic [FRAC_BITS:0]       w_frac,
    input  hsl2rgb_pkg::sector_t     sector_in,
    output logic                     out_valid,
    output logic [FRAC_BITS:0]       c_frac,
    output logic [FRAC_BITS:0]       x_frac,
    output logic [FRAC_BITS:0]       m_frac,
    output hsl2rgb_pkg::sector_t     sector_out
);

    // stage 3: chroma
    logic [2*FRAC_BITS+1:0] c_prod;
    logic                   v3_reg;
    logic [FRAC_BITS:0]     c3_reg;
    logic [FRAC_BITS:0]     l3_reg;
    logic [FRAC_BITS:0]     w3_reg;
    hsl2rgb_pkg::sector_t   sector3_reg;

    assign c_prod = k_frac * s_frac;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        c3_reg      <= c_prod[2*FRAC_BITS:FRAC_BITS];
        l3_reg      <= l_frac;
        w3_reg      <= w_frac;
        sector3_reg <= sector_in;
    end

    // stage 4: secondary component and offset
    logic [2*FRAC_BITS+1:0] x_prod;
    logic [FRAC_BITS:0]     m_next;
    logic                   v4_reg;
    logic [FRAC_BITS:0]     c4_reg;
    logic [FRAC_BITS:0]     x4_reg;
    logic [FRAC_BITS:0]     m4_reg;
    hsl2rgb_pkg::sector_t   sector4_reg;

    assign x_prod = c3_reg * w3_reg;
    assign m_next = l3_reg - {1'b0, c3_reg[FRAC_BITS:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c4_reg      <= c3_reg;
        x4_reg      <= x_prod[2*FRAC_BITS:FRAC_BITS];
        m4_reg      <= m_next;
        sector4_reg <= sector3_reg;
    end

    assign out_valid  = v4_reg;
    assign c_frac     = c4_reg;
    assign x_frac     = x4_reg;
    assign m_frac     = m4_reg;
    assign sector_out = sector4_reg;

endmodule

>>> hw/rtl/hsl2rgb_mix.sv
// output stage: sector channel order, offset, scale to 8 bits and clamp
// depends on hsl2rgb_pkg
module hsl2rgb_mix #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [FRAC_BITS:0]       c_frac,
    input  logic [FRAC_BITS:0]       x_frac,
    input  logic [FRAC_BITS:0]       m_frac,
    input  hsl2rgb_pkg::sector_t     sector,
    output logic                     out_valid,
    output logic [7:0]               red,
    output logic [7:0]               green,
    output logic [7:0]               blue
);

    logic [FRAC_BITS:0]   chan [3];
    logic [FRAC_BITS+1:0] sum  [3];
    logic [FRAC_BITS+9:0] scaled [3];
    logic [9:0]           quot [3];
    logic [7:0]           chan_next [3];

    logic                 done_reg;
    logic [7:0]           red_reg;
    logic [7:0]           green_reg;
    logic [7:0]           blue_reg;

    always_comb
    begin
        case (sector)
            hsl2rgb_pkg::SECTOR_RED_YEL:
            begin
                chan[0] = c_frac;
                chan[1] = x_frac;
                chan[2] = '0;
            end
            hsl2rgb_pkg::SECTOR_YEL_GRN:
            begin
                chan[0] = x_frac;
                chan[1] = c_frac;
                chan[2] = '0;
            end
            hsl2rgb_pkg::SECTOR_GRN_CYN:
            begin
                chan[0] = '0;
                chan[1] = c_frac;
                chan[2] = x_frac;
            end
            hsl2rgb_pkg::SECTOR_CYN_BLU:
            begin
                chan[0] = '0;
                chan[1] = x_frac;
                chan[2] = c_frac;
            end
            hsl2rgb_pkg::SECTOR_BLU_MAG:
            begin
                chan[0] = x_frac;
                chan[1] = '0;
                chan[2] = c_frac;
            end
            default:
            begin
                chan[0] = c_frac;
                chan[1] = '0;
                chan[2] = x_frac;
            end
        endcase
    end

    // times 255 as shift and subtract
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum[i]    = {1'b0, chan[i]} + {1'b0, m_frac};
            scaled[i] = {sum[i], 8'd0} - {8'd0, sum[i]};
            quot[i]   = scaled[i][FRAC_BITS+9:FRAC_BITS];
            chan_next[i] = (quot[i] > 10'(hsl2rgb_pkg::CHAN_MAX))
                         ? 8'(hsl2rgb_pkg::CHAN_MAX) : quot[i][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= chan_next[0];
        green_reg <= chan_next[1];
        blue_reg  <= chan_next[2];
    end

    assign out_valid = done_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

>>> hw/rtl/hsl_to_rgb_converter_unit.sv
// HSL to RGB colour converter: takes one pixel per clock and returns its 8-bit red,
// green and blue for each start, marked by done for one cycle. The pixel passes through
// five register stages: quotient estimate, quotient correction with sector decode,
// chroma multiply, secondary multiply, channel mix and scale. busy is always low, so
// start may be high in every cycle, and results cannot be held off: the receiver must
// take each one in the cycle that done is high.
// depends on hsl2rgb_pkg, hsl2rgb_norm, hsl2rgb_chroma, hsl2rgb_mix
module hsl_to_rgb_converter_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] hue,
    input  logic [15:0] saturation,
    input  logic [15:0] lightness,
    output logic        done,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    logic                 accept;
    logic                 norm_valid;
    logic [FRAC_BITS:0]   s_frac;
    logic [FRAC_BITS:0]   l_frac;
    logic [FRAC_BITS:0]   k_frac;
    logic [FRAC_BITS:0]   w_frac;
    hsl2rgb_pkg::sector_t norm_sector;
    logic                 chroma_valid;
    logic [FRAC_BITS:0]   c_frac;
    logic [FRAC_BITS:0]   x_frac;
    logic [FRAC_BITS:0]   m_frac;
    hsl2rgb_pkg::sector_t chroma_sector;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    hsl2rgb_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .out_valid  (norm_valid),
        .s_frac     (s_frac),
        .l_frac     (l_frac),
        .k_frac     (k_frac),
        .w_frac     (w_frac),
        .sector     (norm_sector)
    );

    hsl2rgb_chroma #(
        .FRAC_BITS (FRAC_BITS)
    ) u_chroma (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (norm_valid),
        .s_frac     (s_frac),
        .l_frac     (l_frac),
        .k_frac     (k_frac),
        .w_frac     (w_frac),
        .sector_in  (norm_sector),
        .out_valid  (chroma_valid),
        .c_frac     (c_frac),
        .x_frac     (x_frac),
        .m_frac     (m_frac),
        .sector_out (chroma_sector)
    );

    hsl2rgb_mix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chroma_valid),
        .c_frac    (c_frac),
        .x_frac    (x_frac),
        .m_frac    (m_frac),
        .sector    (chroma_sector),
        .out_valid (done),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

endmodule

>>> hw/rtl/hsl2rgb_checker.sv
// port-level checks for the hsl to rgb converter, bound to the top level
// depends on hsl2rgb_pkg and hsl_to_rgb_converter_unit_defines.svh
`include "hsl_to_rgb_converter_unit_defines.svh"

module hsl2rgb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [15:0] saturation,
    input logic [15:0] lightness,
    input logic        done,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue
);

    localparam int LAT = hsl2rgb_pkg::PIPE_DEPTH;

    logic accepted;
    logic grey_in;
    logic dark_in;
    logic grey_rgb;
    logic black_rgb;

    assign accepted  = start && !busy;
    assign grey_in   = accepted && (saturation == 16'd0);
    assign dark_in   = accepted && (lightness == 16'd0);
    assign grey_rgb  = (red == green) && (green == blue);
    assign black_rgb = (red == 8'd0) && (green == 8'd0) && (blue == 8'd0);

    `HSL2RGB_ASSERT_ALWAYS(a_never_busy, !busy)
    `HSL2RGB_ASSERT_DELAY(a_done_follows_start, accepted, LAT, done)
    `HSL2RGB_ASSERT_IMPL(a_done_has_start, done, $past(accepted, LAT))
    `HSL2RGB_ASSERT_DELAY(a_grey_when_unsaturated, grey_in, LAT, grey_rgb)
    `HSL2RGB_ASSERT_DELAY(a_black_when_dark, dark_in, LAT, black_rgb)

endmodule

bind hsl_to_rgb_converter_unit hsl2rgb_checker u_checker (.*);
